[design/irpd_pkg.sv]
`default_nettype none

package irpd_pkg;

    // command length and the frame layout that follows from it
    localparam int COMMAND_BITS = 16;
    localparam int FULL_ENTRIES = 2 + 2 * COMMAND_BITS;
    localparam int POS_MAX      = FULL_ENTRIES + 1;
    localparam int POS_W        = $clog2(POS_MAX + 1);
    localparam int REPEAT_LEN   = 3;

    // field and register widths
    localparam int DUR_W = 16;
    localparam int TOL_W = 7;
    localparam int WIN_W = 11;
    localparam int AGE_W = 11;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(25);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(100);
    localparam int PCT_FULL = 100;
    localparam int PCT_W    = 8;

    // apb register map, one 32-bit register every 4 bytes
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_TOL = 1'b0;
    localparam logic REG_WIN = 1'b1;

    // nominal timings in microseconds
    localparam int NOM_N  = 4;
    localparam int NOM_W  = 14;
    localparam int NOM_HDR_MARK    = 0;
    localparam int NOM_LONG_SPACE  = 1;
    localparam int NOM_SHORT_SPACE = 2;
    localparam int NOM_BIT_MARK    = 3;
    localparam logic [NOM_N-1:0][NOM_W-1:0] NOM_US =
        {14'd490, 14'd2205, 14'd4410, 14'd8820};

    // durations and bounds are compared scaled by 100
    localparam int SCALE_W = 23;
    localparam logic [SCALE_W-1:0] ROUND_UP = SCALE_W'(PCT_FULL - 1);

    // candidate flags
    localparam int FLAG_FULL = 0;
    localparam int FLAG_REP  = 1;
    localparam logic [1:0] FLAGS_RESET     = 2'b11;
    localparam logic [1:0] FLAGS_FULL_ONLY = 2'b01;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_REJECT = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_REPEAT = 2'd2
    } status_t;

    typedef struct packed {
        logic                             lo_open;
        logic [NOM_N-1:0][SCALE_W-1:0]    lo;
        logic [NOM_N-1:0][SCALE_W-1:0]    hi;
    } bounds_t;

    typedef struct packed {
        bounds_t           bnd;
        logic [WIN_W-1:0]  win;
    } cfg_t;

    // scaled bounds: nominal times (100 - t) and (100 + t)
    function automatic bounds_t bounds_of(logic [TOL_W-1:0] tol);
        bounds_t            b;
        logic [PCT_W-1:0]   lo_pct;
        logic [PCT_W-1:0]   hi_pct;
        lo_pct    = PCT_W'(PCT_FULL) - PCT_W'(tol);
        hi_pct    = PCT_W'(PCT_FULL) + PCT_W'(tol);
        b.lo_open = (tol >= TOL_W'(PCT_FULL));
        for (int i = 0; i < NOM_N; i++) begin
            b.lo[i] = SCALE_W'(lo_pct) * SCALE_W'(NOM_US[i]);
            b.hi[i] = SCALE_W'(hi_pct) * SCALE_W'(NOM_US[i]);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[design/irpd_regs.sv]
`default_nettype none

module irpd_regs
    import irpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [TOL_W-1:0] tol_reg, tol_next;
    logic [WIN_W-1:0] win_reg, win_next;
    bounds_t          bnd_reg, bnd_next;
    logic             wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        tol_next = tol_reg;
        win_next = win_reg;
        bnd_next = bnd_reg;
        if (wr)
        begin
            unique case (paddr[2])
                REG_TOL:
                begin
                    tol_next = pwdata[TOL_W-1:0];
                    // bounds follow the tolerance at the same edge
                    bnd_next = bounds_of(pwdata[TOL_W-1:0]);
                end
                REG_WIN: win_next = pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            win_reg <= WIN_RESET;
            bnd_reg <= bounds_of(TOL_RESET);
        end
        else
        begin
            tol_reg <= tol_next;
            win_reg <= win_next;
            bnd_reg <= bnd_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TOL: prdata = DATA_W'(tol_reg);
            REG_WIN: prdata = DATA_W'(win_reg);
            default: prdata = '0;
        endcase
    end

    assign cfg.bnd = bnd_reg;
    assign cfg.win = win_reg;

endmodule

`default_nettype wire

[design/irpd_match.sv]
`default_nettype none

module irpd_match
    import irpd_pkg::*;
(
    input  wire bounds_t             bnd,
    input  wire logic [SCALE_W-1:0]  d100,
    input  wire logic [SCALE_W-1:0]  d100_up,
    output logic      [NOM_N-1:0]    near
);

    // floor(x/100) <= d  <=>  x <= 100d + 99 ;  d <= floor(y/100)  <=>  100d <= y
    always_comb
    begin
        for (int i = 0; i < NOM_N; i++)
        begin
            near[i] = (d100 <= bnd.hi[i]) && (bnd.lo_open || (bnd.lo[i] <= d100_up));
        end
    end

endmodule

`default_nettype wire

[design/irpd_frame.sv]
`default_nettype none

module irpd_frame
    import irpd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cfg_t                    cfg,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    kind,
    input  wire logic                    is_mark,
    input  wire logic [DUR_W-1:0]        duration_us,
    input  wire logic                    frame_end,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   status,
    output logic [COMMAND_BITS-1:0]      command
);

    // input stage
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_kind_reg;
    logic               s1_mark_reg;
    logic               s1_end_reg;
    logic [SCALE_W-1:0] s1_d100_reg;
    logic [SCALE_W-1:0] s1_d100_up_reg;
    logic [SCALE_W-1:0] dur_w;
    logic [SCALE_W-1:0] d100;
    logic               take_in;

    // frame state
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [1:0]              flags_reg, flags_next;
    logic [COMMAND_BITS-1:0] shift_reg, shift_next;
    logic [COMMAND_BITS-1:0] last_reg, last_next;
    logic [AGE_W-1:0]        age_reg, age_next;

    // result stage
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [COMMAND_BITS-1:0] command_reg;

    logic                    out_free;
    logic                    adv;
    logic [NOM_N-1:0]        near;
    logic                    win_open;
    logic                    ok, hdr, rep, bit_val;
    logic                    res_valid;
    status_t                 res_status;
    logic [COMMAND_BITS-1:0] res_cmd;

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    // scale the duration by 100 on the way in
    assign dur_w = SCALE_W'(duration_us);
    assign d100  = (dur_w << 6) + (dur_w << 5) + (dur_w << 2);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_kind_reg    <= kind;
            s1_mark_reg    <= is_mark;
            s1_end_reg     <= frame_end;
            s1_d100_reg    <= d100;
            s1_d100_up_reg <= d100 + ROUND_UP;
        end
    end

    irpd_match u_match (
        .bnd     (cfg.bnd),
        .d100    (s1_d100_reg),
        .d100_up (s1_d100_up_reg),
        .near    (near)
    );

    assign win_open = (age_reg != AGE_MAX) && (age_reg <= cfg.win);

    always_comb
    begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        shift_next = shift_reg;
        last_next  = last_reg;
        age_next   = age_reg;
        ok         = 1'b0;
        hdr        = 1'b0;
        rep        = 1'b0;
        bit_val    = 1'b0;
        res_valid  = 1'b0;
        res_status = STATUS_REJECT;
        res_cmd    = '0;
        if (adv)
        begin
            if (s1_kind_reg == KIND_TICK)
            begin
                if (age_reg != AGE_MAX)
                    age_next = age_reg + 1'b1;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    if (!(s1_mark_reg && near[NOM_HDR_MARK]))
                        flags_next = '0;
                end
                else if (pos_reg == POS_W'(1))
                begin
                    // a full header wins over a repeat header
                    ok         = flags_reg[FLAG_FULL] && !s1_mark_reg;
                    hdr        = ok && near[NOM_LONG_SPACE];
                    rep        = ok && !hdr && near[NOM_SHORT_SPACE];
                    flags_next = {rep, hdr};
                end
                else if (pos_reg < POS_W'(FULL_ENTRIES))
                begin
                    if (!pos_reg[0])
                    begin
                        if (!(s1_mark_reg && near[NOM_BIT_MARK]))
                            flags_next = '0;
                    end
                    else
                    begin
                        flags_next = flags_reg & FLAGS_FULL_ONLY;
                        if (!s1_mark_reg && near[NOM_LONG_SPACE])
                            bit_val = 1'b1;
                        else if (!s1_mark_reg && near[NOM_SHORT_SPACE])
                            bit_val = 1'b0;
                        else
                            flags_next = '0;
                        shift_next = COMMAND_BITS'({shift_reg, bit_val});
                    end
                end
                else
                begin
                    flags_next = flags_reg & FLAGS_FULL_ONLY;
                end

                if (pos_reg < POS_W'(POS_MAX))
                    pos_next = pos_reg + 1'b1;

                if (s1_end_reg)
                begin
                    res_valid = 1'b1;
                    if (flags_next[FLAG_FULL] && (pos_next >= POS_W'(FULL_ENTRIES)))
                    begin
                        res_status = STATUS_FULL;
                        res_cmd    = shift_next;
                        last_next  = shift_next;
                        age_next   = '0;
                    end
                    else if (flags_next[FLAG_REP] && (pos_next == POS_W'(REPEAT_LEN))
                             && win_open)
                    begin
                        res_status = STATUS_REPEAT;
                        res_cmd    = last_reg;
                        age_next   = '0;
                    end
                    pos_next   = '0;
                    flags_next = FLAGS_RESET;
                    shift_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            flags_reg     <= FLAGS_RESET;
            shift_reg     <= '0;
            last_reg      <= '0;
            age_reg       <= AGE_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pos_reg      <= pos_next;
            flags_reg    <= flags_next;
            shift_reg    <= shift_next;
            last_reg     <= last_next;
            age_reg      <= age_next;
            if (out_free)
                out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            status_reg  <= res_status;
            command_reg <= res_cmd;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign command   = command_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POS_MAX))
        else $error("entry position beyond saturation");

    a_full_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_FULL) |-> (last_reg == command_reg))
        else $error("full frame beat does not match stored command");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_REJECT) |-> (command_reg == '0))
        else $error("rejected beat carries a command");

    a_age_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status != STATUS_REJECT) |=> (age_reg == '0))
        else $error("accepted frame did not restart the window");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

[design/ir_pulse_distance_decoder.sv]
`default_nettype none

// Pulse-distance infrared remote decoder. Each input beat is either one captured
// mark/space duration or a one-millisecond tick. Durations are checked against the
// nominal timings within tolerance_percent; a frame ends on the duration beat with
// frame_end set, and exactly that beat produces one result (ticks never do): status 1
// with the 16-bit command of a full frame (8820/4410 header, then 490 mark plus 4410
// or 2205 space per bit, msb first), status 2 with the last command for a repeat frame
// that arrives while no more than repeat_window_ms ticks have passed since the last
// accepted frame, or status 0 with command 0. The window starts out expired after
// reset. The block takes one beat per cycle while in_stall is low; out_valid rises
// once the closing beat has passed the input register and then the result register.
// in_stall rises only while a finished result is held by out_stall and another beat
// is waiting in the input register.
// Registers: tolerance_percent at 0x0, repeat_window_ms at 0x4; change them only
// while no frame is in flight.
module ir_pulse_distance_decoder
    import irpd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic                     is_mark,
    input  wire logic [DUR_W-1:0]         duration_us,
    input  wire logic                     frame_end,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [1:0]               status,
    output logic      [COMMAND_BITS-1:0]  command
);

    cfg_t cfg;

    irpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .is_mark     (is_mark),
        .duration_us (duration_us),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .command     (command)
    );

endmodule

`default_nettype wire
